/* rtl/core/cssw_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cssw_pkg: shared types and microcode for the capture stream stall watchdog
// Holds the channel payload structs, register indexes, verdict codes,
// datapath constants and the read-only control store of the sequencer.
// ---------------------------------------------------------------------------
package cssw_pkg;

   // Block limits
   localparam int MAX_SLOW_LIMIT = 16;
   localparam int TIME_BITS      = 48;

   // Times are kept to TIME_BITS bits of the 48-bit time field
   localparam logic [47:0] TIME_MASK =
      (TIME_BITS >= 48) ? {48{1'b1}} : ((48'd1 << TIME_BITS) - 48'd1);

   // Configuration register indexes
   localparam logic [2:0] CSR_TARGET_BYTES   = 3'd0;
   localparam logic [2:0] CSR_EXPECTED_RATE  = 3'd1;
   localparam logic [2:0] CSR_CHUNK_BYTES    = 3'd2;
   localparam logic [2:0] CSR_SLOW_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_IDLE_LIMIT_US  = 3'd4;

   // Register reset values
   localparam logic [4:0]  SLOW_THRESHOLD_RST = 5'd1;
   localparam logic [31:0] IDLE_LIMIT_RST     = 32'd1000000;

   // Slow test scale factors: 1.3 * 1e6 and 1e7
   localparam logic [31:0] CHUNK_SCALE = 32'd1300000;
   localparam logic [31:0] GOT_SCALE   = 32'd10000000;

   // Slow counter ceiling
   localparam logic [4:0] SLOW_RUN_MAX = 5'd31;

   typedef enum logic [2:0] {
      V_OK    = 3'd0,
      V_DONE  = 3'd1,
      V_RETRY = 3'd2,
      V_WARN  = 3'd3,
      V_ABORT = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [31:0]        rx_bytes;
      logic [47:0]        now_us;
      logic signed [31:0] gap_us;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [47:0] total_bytes;
   } rsp_type;

   // Multiplier operand pair
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_RATE,
      MUL_CHUNK,
      MUL_GOT
   } mul_sel_type;

   // Datapath operation of one step
   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCUM,
      OP_SAVE_RATE,
      OP_CMP_LIM,
      OP_SCALE_IDLE,
      OP_CMP_NEED,
      OP_VERDICT
   } op_type;

   // Jump condition
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_SKIP,
      JMP_HOLD
   } jmp_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FIRST   = 3'd0;
   localparam step_type STEP_VERDICT = 3'd5;

   typedef struct packed {
      mul_sel_type mul_sel;
      op_type      op;
      jmp_type     jmp;
      step_type    target;
      logic        last;
   } ctrl_word_type;

   // Control store: one word per step
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type cw;
      case (step)
         3'd0:    cw = '{MUL_RATE,  OP_ACCUM,      JMP_NEXT, STEP_FIRST,   1'b0};
         3'd1:    cw = '{MUL_CHUNK, OP_SAVE_RATE,  JMP_SKIP, STEP_VERDICT, 1'b0};
         3'd2:    cw = '{MUL_GOT,   OP_CMP_LIM,    JMP_NEXT, STEP_FIRST,   1'b0};
         3'd3:    cw = '{MUL_NONE,  OP_SCALE_IDLE, JMP_NEXT, STEP_FIRST,   1'b0};
         3'd4:    cw = '{MUL_NONE,  OP_CMP_NEED,   JMP_NEXT, STEP_FIRST,   1'b0};
         3'd5:    cw = '{MUL_NONE,  OP_VERDICT,    JMP_HOLD, STEP_VERDICT, 1'b1};
         default: cw = '{MUL_NONE,  OP_NOP,        JMP_NEXT, STEP_FIRST,   1'b1};
      endcase
      return cw;
   endfunction

endpackage

/* rtl/core/capture_stream_stall_watchdog_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// capture_stream_stall_watchdog_top: stall watchdog for a capture stream
// Judges each transfer completion item and returns a verdict with the
// running byte total, driven by a small microcoded sequencer.
// ---------------------------------------------------------------------------
// One item is worked on at a time. An accepted item runs a six-step
// microprogram over one shared 32x32 multiplier: it updates the byte total
// and times, forms the three products of the slow test, compares them,
// checks the idle time and loads the verdict into the output register. The
// result is loaded after steps 0 to 5 in order, or after steps 0, 1 and 5
// when the verdict is done or the speed test does not apply (step 1 jumps to
// the verdict step). The next item is accepted while a result still waits in
// the output register; the verdict step holds only while that register is
// full and stalled. Configuration writes take effect at the edge where csr_we
// is high; indexes above 4 are ignored.
// ---------------------------------------------------------------------------
module capture_stream_stall_watchdog_top #(
   parameter int SLOW_LIMIT = cssw_pkg::MAX_SLOW_LIMIT,
   parameter int TIME_WIDTH = cssw_pkg::TIME_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cssw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cssw_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [47:0]       csr_wdata
);
   import cssw_pkg::*;

   localparam logic [6:0]  MaxSlow  = 7'(SLOW_LIMIT);
   localparam logic [47:0] TimeMask =
      (TIME_WIDTH >= 48) ? {48{1'b1}} : ((48'd1 << TIME_WIDTH) - 48'd1);

   // Configuration registers
   logic [47:0] target_ff,   target_in;
   logic [31:0] exp_rate_ff, exp_rate_in;
   logic [31:0] chunk_ff,    chunk_in;
   logic [4:0]  thr_ff,      thr_in;
   logic [31:0] idle_lim_ff, idle_lim_in;

   // Sequencer
   logic     busy_ff, busy_in;
   step_type pc_ff,   pc_in;
   ctrl_word_type cw;
   logic     hold;
   logic     take_jump;
   logic     req_accept;

   // Watchdog state
   logic [47:0] total_ff,   total_in;
   logic [47:0] start_ff,   start_in;
   logic [47:0] last_ff,    last_in;
   logic [4:0]  run_ff,     run_in;
   logic        retried_ff, retried_in;
   logic        warned_ff,  warned_in;

   // Datapath
   req_type     item_ff,      item_in;
   logic [63:0] prod_ff,      prod_in;
   logic [63:0] rate_prod_ff, rate_prod_in;
   logic [66:0] scaled_ff,    scaled_in;
   logic        slow_ff,      slow_in;
   logic        done_ff,      done_in;
   logic        idle_ff,      idle_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;
   logic    rsp_load;

   // Combinational helpers
   logic [47:0] now_m;
   logic        since_pos;
   logic        speed_off;
   logic        done_now;
   logic        skip;
   logic [31:0] mul_a, mul_b;
   logic [48:0] sum;
   logic [47:0] ref_time;
   logic [48:0] diff;
   logic        idle_now;
   logic [4:0]  run_next;
   logic [6:0]  thr_w;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Decode the current step
   assign cw        = ucode(pc_ff);
   assign hold      = rsp_valid_ff && rsp_stall;
   assign take_jump = (cw.jmp == JMP_SKIP && skip) || (cw.jmp == JMP_HOLD && hold);
   assign rsp_load  = busy_ff && cw.op == OP_VERDICT && !hold;

   // Shared conditions
   assign now_m     = item_ff.now_us & TimeMask;
   assign since_pos = item_ff.gap_us != 32'sd0 && !item_ff.gap_us[31];
   assign speed_off = !since_pos || exp_rate_ff == 32'd0 || chunk_ff == 32'd0;
   assign done_now  = target_ff != 48'd0 && total_ff >= target_ff;
   assign skip      = done_now || speed_off;
   assign sum       = {1'b0, total_ff} + {17'd0, item_ff.rx_bytes};
   assign ref_time  = (last_ff != 48'd0) ? last_ff : start_ff;
   assign diff      = {1'b0, now_m} - {1'b0, ref_time};
   assign idle_now  = !diff[48] && diff[47:0] > {16'd0, idle_lim_ff};

   // Select multiplier operands
   always_comb begin
      case (cw.mul_sel)
         MUL_RATE: begin
            mul_a = item_ff.gap_us;
            mul_b = exp_rate_ff;
         end
         MUL_CHUNK: begin
            mul_a = chunk_ff;
            mul_b = CHUNK_SCALE;
         end
         MUL_GOT: begin
            mul_a = item_ff.rx_bytes;
            mul_b = GOT_SCALE;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   // Slow counter and threshold for the verdict step
   always_comb begin
      if (!slow_ff) begin
         run_next = 5'd0;
      end else if (run_ff == SLOW_RUN_MAX) begin
         run_next = SLOW_RUN_MAX;
      end else begin
         run_next = run_ff + 5'd1;
      end
      thr_w = (thr_ff == 5'd0) ? 7'd1 : {2'd0, thr_ff};
      if (thr_w > MaxSlow) begin
         thr_w = MaxSlow;
      end
   end

   // Configuration writes
   always_comb begin
      target_in   = target_ff;
      exp_rate_in = exp_rate_ff;
      chunk_in    = chunk_ff;
      thr_in      = thr_ff;
      idle_lim_in = idle_lim_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TARGET_BYTES:   target_in   = csr_wdata;
            CSR_EXPECTED_RATE:  exp_rate_in = csr_wdata[31:0];
            CSR_CHUNK_BYTES:    chunk_in    = csr_wdata[31:0];
            CSR_SLOW_THRESHOLD: thr_in      = csr_wdata[4:0];
            CSR_IDLE_LIMIT_US:  idle_lim_in = csr_wdata[31:0];
            default:            ;
         endcase
      end
   end

   // Advance the step counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      item_in = item_ff;
      if (!busy_ff) begin
         if (req_accept) begin
            busy_in = 1'b1;
            pc_in   = STEP_FIRST;
            item_in = req_payload;
         end
      end else if (take_jump) begin
         pc_in = cw.target;
      end else if (cw.last) begin
         busy_in = 1'b0;
      end else begin
         pc_in = pc_ff + 3'd1;
      end
   end

   // Datapath operations of the current step
   always_comb begin
      total_in     = total_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      run_in       = run_ff;
      retried_in   = retried_ff;
      warned_in    = warned_ff;
      prod_in      = prod_ff;
      rate_prod_in = rate_prod_ff;
      scaled_in    = scaled_ff;
      slow_in      = slow_ff;
      done_in      = done_ff;
      idle_in      = idle_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (busy_ff) begin
         if (cw.mul_sel != MUL_NONE) begin
            prod_in = mul_a * mul_b;
         end
         case (cw.op)
            OP_ACCUM: begin
               if (start_ff == 48'd0) begin
                  start_in = now_m;
               end
               if (item_ff.rx_bytes != 32'd0) begin
                  total_in = sum[48] ? {48{1'b1}} : sum[47:0];
                  last_in  = now_m;
               end
            end
            OP_SAVE_RATE: begin
               rate_prod_in = prod_ff;
               done_in      = done_now;
            end
            OP_CMP_LIM: begin
               slow_in = rate_prod_ff > prod_ff;
            end
            OP_SCALE_IDLE: begin
               scaled_in = {rate_prod_ff, 3'd0} - {3'd0, rate_prod_ff};
               idle_in   = idle_now;
            end
            OP_CMP_NEED: begin
               slow_in = slow_ff || scaled_ff > {3'd0, prod_ff};
            end
            OP_VERDICT: begin
               if (rsp_load) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.total_bytes = total_ff;
                  rsp_in.verdict     = V_OK;
                  if (done_ff) begin
                     rsp_in.verdict = V_DONE;
                  end else if (speed_off) begin
                     rsp_in.verdict = V_OK;
                  end else if (total_ff == 48'd0) begin
                     run_in = run_next;
                     if ({2'd0, run_next} >= thr_w) begin
                        if (!retried_ff) begin
                           retried_in     = 1'b1;
                           run_in         = 5'd0;
                           rsp_in.verdict = V_RETRY;
                        end else begin
                           rsp_in.verdict = V_ABORT;
                        end
                     end
                  end else if (idle_ff) begin
                     rsp_in.verdict = V_ABORT;
                  end else if (slow_ff && !warned_ff) begin
                     warned_in      = 1'b1;
                     rsp_in.verdict = V_WARN;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Register update
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= 48'd0;
         exp_rate_ff  <= 32'd0;
         chunk_ff     <= 32'd0;
         thr_ff       <= SLOW_THRESHOLD_RST;
         idle_lim_ff  <= IDLE_LIMIT_RST;
         busy_ff      <= 1'b0;
         pc_ff        <= STEP_FIRST;
         total_ff     <= 48'd0;
         start_ff     <= 48'd0;
         last_ff      <= 48'd0;
         run_ff       <= 5'd0;
         retried_ff   <= 1'b0;
         warned_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         exp_rate_ff  <= exp_rate_in;
         chunk_ff     <= chunk_in;
         thr_ff       <= thr_in;
         idle_lim_ff  <= idle_lim_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         run_ff       <= run_in;
         retried_ff   <= retried_in;
         warned_ff    <= warned_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      prod_ff      <= prod_in;
      rate_prod_ff <= rate_prod_in;
      scaled_ff    <= scaled_in;
      slow_ff      <= slow_in;
      done_ff      <= done_in;
      idle_ff      <= idle_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTH
   // An accepted item starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff && pc_ff == STEP_FIRST)
      else $error("item accepted without starting the microprogram");

   // A result appears only after the verdict step
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff) && $past(pc_ff) == STEP_VERDICT)
      else $error("result loaded outside the verdict step");

   // A retry verdict sets the once-only retry flag
   a_retry_once: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_in.verdict == V_RETRY |=> retried_ff)
      else $error("retry issued without marking it done");

   // The step counter stays within the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= STEP_VERDICT)
      else $error("step counter left the microprogram");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the capture stream stall watchdog
// Feeds transfer-completion items through the req channel, predicts verdict
// and byte total per item with an independent model of the watchdog, and
// checks every result in order. A directed table runs first (pre-data retry
// and abort, slow counting, zero and backward time, register masking), then
// randomized phases under several idle/stall mixes, then a short burst of
// full-size items back to back.
// ---------------------------------------------------------------------------
module tb_top;
   import cssw_pkg::*;

   localparam logic [47:0] MAX48         = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32         = 32'hFFFF_FFFF;
   localparam logic [31:0] SINCE_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] SINCE_MIN     = 32'h8000_0000;
   localparam logic [2:0]  CSR_UNUSED_LO = 3'd5;
   localparam logic [2:0]  CSR_UNUSED_HI = 3'd7;
   localparam int          CYCLE_LIMIT   = 2000000;
   localparam int          DRAIN_CYCLES  = 12;
   localparam int          RAND_PHASES   = 8;
   localparam int          PHASE_ITEMS   = 75;
   localparam int          BURST_ITEMS   = 10;

   // One row of the directed table: a register write or a repeated item
   typedef struct packed {
      logic        is_csr;
      logic [2:0]  idx;
      logic [47:0] wdata;
      req_type     ev;
      logic [7:0]  reps;
      logic        typed;
      rsp_type     exp_rsp;
   } dir_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we      = 1'b0;
   logic [2:0]  csr_index   = 3'd0;
   logic [47:0] csr_wdata   = 48'd0;

   // Watchdog copy: registers
   logic [47:0] cfg_target = 48'd0;
   logic [31:0] cfg_rate   = 32'd0;
   logic [31:0] cfg_chunk  = 32'd0;
   logic [4:0]  cfg_thr    = SLOW_THRESHOLD_RST;
   logic [31:0] cfg_idle   = IDLE_LIMIT_RST;

   // Watchdog copy: state
   logic [47:0] acc_total   = 48'd0;
   logic [47:0] t_start     = 48'd0;
   logic [47:0] t_last_data = 48'd0;
   logic [4:0]  slow_streak = 5'd0;
   logic        retried     = 1'b0;
   logic        warned      = 1'b0;

   rsp_type     pending_verdicts[$];
   dir_row_type dir_rows[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   logic [47:0] gen_now        = 48'd0;
   logic [63:0] gen_interval   = 64'd1000;

   capture_stream_stall_watchdog_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Exact slow test: interval over 1.3x the chunk time, or rate under 0.7x
   function automatic logic is_slow(input logic [31:0] got, input logic [31:0] t);
      logic [71:0] late_lhs, late_rhs, rate_lhs, rate_rhs;
      late_lhs = 72'(t) * 72'(cfg_rate) * 72'd10;
      late_rhs = 72'd13000000 * 72'(cfg_chunk);
      rate_lhs = 72'd10000000 * 72'(got);
      rate_rhs = 72'd7 * 72'(cfg_rate) * 72'(t);
      return (late_lhs > late_rhs) || (rate_lhs < rate_rhs);
   endfunction

   // Advance the watchdog copy by one completion and return its verdict
   function automatic rsp_type judge_completion(input req_type ev);
      rsp_type     res;
      logic [47:0] now_t, idle_ref;
      logic [48:0] acc_sum;
      logic [4:0]  thr_eff;
      logic        since_pos, slow;
      now_t     = ev.now_us & TIME_MASK;
      since_pos = !ev.gap_us[31] && (ev.gap_us != 32'd0);
      res.verdict = V_OK;
      if (t_start == 48'd0) t_start = now_t;
      if (ev.rx_bytes != 32'd0) begin
         acc_sum = {1'b0, acc_total} + 49'(ev.rx_bytes);
         acc_total = (acc_sum > {1'b0, MAX48}) ? MAX48 : acc_sum[47:0];
         t_last_data = now_t;
      end
      if (cfg_target != 48'd0 && acc_total >= cfg_target) begin
         res.verdict = V_DONE;
      end else if (since_pos && cfg_rate != 32'd0 && cfg_chunk != 32'd0) begin
         slow = is_slow(ev.rx_bytes, ev.gap_us);
         if (acc_total == 48'd0) begin
            // Before data: count slow events, retry once, then abort
            if (!slow) slow_streak = 5'd0;
            else if (slow_streak != SLOW_RUN_MAX) slow_streak = slow_streak + 5'd1;
            if (cfg_thr == 5'd0) thr_eff = 5'd1;
            else if (cfg_thr > 5'(MAX_SLOW_LIMIT)) thr_eff = 5'(MAX_SLOW_LIMIT);
            else thr_eff = cfg_thr;
            if (slow_streak >= thr_eff) begin
               if (!retried) begin
                  retried     = 1'b1;
                  slow_streak = 5'd0;
                  res.verdict = V_RETRY;
               end else begin
                  res.verdict = V_ABORT;
               end
            end
         end else begin
            // Data flowing: idle timeout first, then a single slow warning
            idle_ref = (t_last_data != 48'd0) ? t_last_data : t_start;
            if (now_t > idle_ref && (now_t - idle_ref) > 48'(cfg_idle)) begin
               res.verdict = V_ABORT;
            end else if (slow && !warned) begin
               warned = 1'b1;
               res.verdict = V_WARN;
            end
         end
      end
      res.total_bytes = acc_total;
      return res;
   endfunction

   function automatic void set_register(input logic [2:0] idx, input logic [47:0] data);
      case (idx)
         CSR_TARGET_BYTES:   cfg_target = data;
         CSR_EXPECTED_RATE:  cfg_rate   = data[31:0];
         CSR_CHUNK_BYTES:    cfg_chunk  = data[31:0];
         CSR_SLOW_THRESHOLD: cfg_thr    = data[4:0];
         CSR_IDLE_LIMIT_US:  cfg_idle   = data[31:0];
         default: ;
      endcase
   endfunction

   // Directed table builders
   function automatic void add_csr(input logic [2:0] idx, input logic [47:0] data);
      dir_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.wdata  = data;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_item(input logic [31:0] got, input logic [47:0] now_t,
                                    input logic [31:0] since, input logic [7:0] reps);
      dir_row_type row;
      row             = '0;
      row.ev.rx_bytes = got;
      row.ev.now_us   = now_t;
      row.ev.gap_us   = since;
      row.reps        = reps;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [31:0] got, input logic [47:0] now_t,
                                     input logic [31:0] since, input verdict_type v,
                                     input logic [47:0] total);
      add_item(got, now_t, since, 8'd1);
      dir_rows[$].typed               = 1'b1;
      dir_rows[$].exp_rsp.verdict     = v;
      dir_rows[$].exp_rsp.total_bytes = total;
   endfunction

   function automatic void set_idling(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
         default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
      endcase
   endfunction

   // Mostly well-paced completions around the configured chunk time,
   // with jumps to the idle limit, steps back in time and raw noise
   function automatic req_type next_event();
      req_type     ev;
      logic [47:0] stride;
      int          pick;
      pick = $urandom_range(99);
      ev.gap_us = $urandom;
      if (pick < 6) begin
         ev.rx_bytes = 32'd0;
         ev.now_us   = {16'($urandom), 32'($urandom)};
      end else if (pick < 12) begin
         ev.rx_bytes = $urandom;
         gen_now     = gen_now + 48'($urandom_range(10000));
         ev.now_us   = gen_now;
      end else begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            stride  = 48'($urandom_range(1000, 1));
            gen_now = gen_now - stride;
         end else begin
            if (pick < 10) stride = 48'(cfg_idle) + 48'($urandom_range(1));
            else stride = 48'(gen_interval * $urandom_range(150, 60) / 100) + 48'd1;
            gen_now = gen_now + stride;
         end
         ev.gap_us = (stride > 48'(SINCE_MAX)) ? SINCE_MAX : stride[31:0];
         ev.now_us = gen_now;
         if ($urandom_range(99) < 20) ev.rx_bytes = 32'd0;
         else if (cfg_chunk == 32'd0) ev.rx_bytes = $urandom_range(4096);
         else ev.rx_bytes = 32'(64'(cfg_chunk) * $urandom_range(120, 50) / 100);
      end
      return ev;
   endfunction

   // Offer one item, hold it until accepted, record what it should produce
   task automatic send_item(input req_type ev, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = judge_completion(ev);
      pending_verdicts.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [47:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      set_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Pause the sender until every pending verdict is back
   task automatic wait_drain();
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure_phase(input int ph);
      logic [31:0] rate, chunk, idle;
      logic [47:0] target;
      logic [4:0]  thr;
      logic [63:0] span;
      rate   = $urandom_range(1000000000, 100000);
      chunk  = $urandom_range(1 << 20, 1);
      thr    = 5'($urandom_range(31));
      target = 48'd0;
      case (ph)
         0: begin
            rate  = MAX32;
            chunk = MAX32;
            thr   = 5'd16;
         end
         1: rate = 32'd0;
         2: chunk = 32'd0;
         default: ;
      endcase
      if (rate == 32'd0 || chunk == 32'd0) gen_interval = 64'd1000;
      else gen_interval = 64'(chunk) * 64'd1000000 / 64'(rate);
      if (gen_interval == 64'd0) gen_interval = 64'd1;
      if (gen_interval > 64'd1073741824) gen_interval = 64'd1073741824;
      span = gen_interval * $urandom_range(10, 2);
      idle = (ph == 0 || span > 64'(MAX32)) ? MAX32 : span[31:0];
      if (ph == 1 || (ph > 2 && $urandom_range(1) == 1))
         target = acc_total + 48'(64'(chunk) * $urandom_range(60, 20));
      // Upper bits are junk on purpose: the block keeps only the register width
      csr_write(CSR_TARGET_BYTES, target);
      csr_write(CSR_EXPECTED_RATE, {16'($urandom), rate});
      csr_write(CSR_CHUNK_BYTES, {16'($urandom), chunk});
      csr_write(CSR_SLOW_THRESHOLD, {43'($urandom), thr});
      csr_write(CSR_IDLE_LIMIT_US, {16'($urandom), idle});
   endtask

   // Receiver stalls
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Check each delivered result against the oldest pending verdict
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no item pending: verdict %0d total_bytes %0d",
                   rsp_payload.verdict, rsp_payload.total_bytes);
            mismatch_count++;
         end else begin
            exp_rsp = pending_verdicts.pop_front();
            if (rsp_payload.verdict !== exp_rsp.verdict) begin
               $error("verdict: expected %0d, actual %0d",
                      exp_rsp.verdict, rsp_payload.verdict);
               mismatch_count++;
            end
            if (rsp_payload.total_bytes !== exp_rsp.total_bytes) begin
               $error("total_bytes: expected %0d, actual %0d",
                      exp_rsp.total_bytes, rsp_payload.total_bytes);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the bench itself
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      req_type ev;
      // Before any data: zero and negative history, retry then abort
      add_typed(32'd0, 48'd0, 32'd0, V_OK, 48'd0);
      add_typed(32'd0, 48'd50, SINCE_MIN, V_OK, 48'd0);
      add_csr(CSR_SLOW_THRESHOLD, 48'hFFFF_FFFF_FFE0);
      add_csr(CSR_EXPECTED_RATE, MAX48);
      add_csr(CSR_CHUNK_BYTES, 48'd1);
      add_typed(32'd0, 48'd100, SINCE_MAX, V_RETRY, 48'd0);
      add_typed(32'd0, 48'd200, 32'd1, V_ABORT, 48'd0);
      add_csr(CSR_UNUSED_LO, MAX48);
      add_csr(CSR_UNUSED_HI, 48'd0);
      // Slow counting against a threshold, then the clamp and the ceiling
      add_csr(CSR_SLOW_THRESHOLD, 48'd3);
      add_item(32'd0, 48'd300, 32'd7, 8'd2);
      add_csr(CSR_SLOW_THRESHOLD, 48'd31);
      add_item(32'd0, 48'd500, 32'd9, 8'd30);
      // First data at time zero: idle measured from the start time
      add_csr(CSR_EXPECTED_RATE, 48'd1000000);
      add_csr(CSR_CHUNK_BYTES, 48'd1000);
      add_item(32'd1, 48'd0, 32'd1000, 8'd1);
      add_item(32'd0, 48'd1000051, 32'd1000, 8'd1);
      add_item(32'd0, 48'd1000050, 32'd1000, 8'd1);
      add_item(32'd1000, 48'd2000000, 32'd1300, 8'd1);
      // Zero idle limit
      add_csr(CSR_IDLE_LIMIT_US, 48'd0);
      add_item(32'd0, 48'd2000001, 32'd5, 8'd1);
      add_item(32'd0, 48'd2000000, 32'd5, 8'd1);
      add_csr(CSR_IDLE_LIMIT_US, 48'(MAX32));
      // Target met, then the widest target and the largest item
      add_csr(CSR_TARGET_BYTES, 48'd1);
      add_typed(32'd0, MAX48, SINCE_MAX, V_DONE, 48'd1001);
      add_csr(CSR_TARGET_BYTES, MAX48);
      add_item(MAX32, 48'd3000000000, SINCE_MAX, 8'd1);
      add_csr(CSR_TARGET_BYTES, 48'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            req_valid <= 1'b0;
            wait_drain();
            csr_write(dir_rows[i].idx, dir_rows[i].wdata);
         end else begin
            repeat (dir_rows[i].reps)
               send_item(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].exp_rsp);
         end
      end
      req_valid <= 1'b0;
      wait_drain();

      // Randomized phases, each with its own settings and idle mix
      gen_now = 48'd3000001000;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         configure_phase(ph);
         set_idling(ph);
         repeat (PHASE_ITEMS) send_item(next_event(), 1'b0, '0);
         req_valid <= 1'b0;
         set_idling(0);
         wait_drain();
      end

      // Full-size items back to back with the speed test off
      csr_write(CSR_TARGET_BYTES, MAX48);
      csr_write(CSR_EXPECTED_RATE, 48'd0);
      csr_write(CSR_CHUNK_BYTES, 48'd0);
      repeat (BURST_ITEMS) begin
         gen_now     = gen_now + 48'($urandom_range(100, 1));
         ev.rx_bytes = MAX32;
         ev.now_us   = gen_now;
         ev.gap_us   = $urandom;
         send_item(ev, 1'b0, '0);
      end
      req_valid <= 1'b0;
      wait_drain();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
